### rtl/aes256_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// aes256_pkg
// Shared types, constants and byte functions for the AES-256 encrypt block.
// ---------------------------------------------------------------------------
package aes256_pkg;

  localparam int KEY_WORDS  = 4;
  localparam int LAST_ROUND = 14;
  localparam int CFG_IDX_W  = 3;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } plain_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_t;

  localparam logic [2047:0] SBOX_TAB = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  function automatic logic [7:0] sbox(input logic [7:0] v);
    return SBOX_TAB[{~v, 3'b000} +: 8];
  endfunction

  // multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage
`default_nettype wire

### rtl/aes256_block_encrypt.sv
`default_nettype none
// ---------------------------------------------------------------------------
// aes256_block_encrypt
// AES-256 block encryption with an iterative round unit and a round key
// memory filled by an on-chip key schedule.
// ---------------------------------------------------------------------------
//  channel  direction  handshake             beat
//  in       sink       in_valid / in_stall   one plaintext block
//  out      source     out_valid / out_stall one ciphertext block
//  cfg      sink       cfg_we                one key word
//
//  a block is accepted, then makes 15 passes of the round unit
//  after a key word write, the next block first runs the key schedule,
//  which fills all 15 round key rows, one round key row per cycle
//  reset clears the key words and marks the round keys stale
//  in_stall is high while a block is in flight; a finished block waits in
//  the working register while the output beat is stalled
// ---------------------------------------------------------------------------
module aes256_block_encrypt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  aes256_pkg::plain_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output aes256_pkg::cipher_t               out_data,
  input  logic                              cfg_we,
  input  logic [aes256_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                       cfg_data
);
  import aes256_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXPAND = 2'd1;
  localparam logic [1:0] ST_ROUND  = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  localparam logic [3:0] CNT_LAST = 4'(LAST_ROUND);

  logic [1:0]   state;
  logic [3:0]   cnt;
  logic         keys_ready;
  logic [63:0]  key [KEY_WORDS];
  logic [255:0] win;
  logic [127:0] st;
  logic [127:0] rk_mem [LAST_ROUND + 1];
  logic [127:0] rk_q;
  logic [3:0]   rd_idx;
  logic [127:0] exp_row;
  logic [127:0] exp_new;
  logic [31:0]  exp_t;
  logic [7:0]   rcon;
  logic [127:0] rnd_out;
  logic         cfg_hit;
  logic         in_acc;
  logic         fin_ok;
  logic         fin_fire;

  assign cfg_hit  = cfg_we && (cfg_index < CFG_IDX_W'(KEY_WORDS));
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign fin_ok   = !out_valid || !out_stall;
  assign fin_fire = fin_ok && ((state == ST_ROUND && cnt == CNT_LAST) || state == ST_DONE);

  // key schedule, four words per row
  always_comb begin
    rcon = 8'(8'h01 << (cnt[3:1] - 3'd1));
    if (!cnt[0]) begin
      exp_t = sub_word({win[23:0], win[31:24]}) ^ {rcon, 24'h000000};
    end else begin
      exp_t = sub_word(win[31:0]);
    end
    exp_new[127:96] = win[255:224] ^ exp_t;
    exp_new[95:64]  = win[223:192] ^ exp_new[127:96];
    exp_new[63:32]  = win[191:160] ^ exp_new[95:64];
    exp_new[31:0]   = win[159:128] ^ exp_new[63:32];
    case (cnt)
      4'd0:    exp_row = {key[0], key[1]};
      4'd1:    exp_row = win[127:0];
      default: exp_row = exp_new;
    endcase
  end

  always_comb begin
    if (state == ST_ROUND && cnt != CNT_LAST) begin
      rd_idx = cnt + 4'd1;
    end else begin
      rd_idx = 4'd0;
    end
  end

  aes256_round u_round (
    .state  (st),
    .rkey   (rk_q),
    .first  (cnt == 4'd0),
    .last   (cnt == CNT_LAST),
    .result (rnd_out)
  );

  always_ff @(posedge clk) begin
    if (state == ST_EXPAND) begin
      rk_mem[cnt] <= exp_row;
    end
    rk_q <= rk_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= 4'd0;
      keys_ready <= 1'b0;
      out_valid  <= 1'b0;
      for (int k = 0; k < KEY_WORDS; k++) begin
        key[k] <= 64'd0;
      end
    end else begin
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            st    <= in_data;
            cnt   <= 4'd0;
            state <= (!keys_ready || cfg_hit) ? ST_EXPAND : ST_ROUND;
          end
        end
        ST_EXPAND: begin
          if (cnt == 4'd0) begin
            win <= {key[0], key[1], key[2], key[3]};
          end else if (cnt != 4'd1) begin
            win <= {win[127:0], exp_new};
          end
          if (cnt == CNT_LAST) begin
            cnt   <= 4'd0;
            state <= ST_ROUND;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_ROUND: begin
          st <= rnd_out;
          if (cnt == CNT_LAST) begin
            cnt <= 4'd0;
            if (fin_ok) begin
              out_data <= rnd_out;
              state    <= ST_IDLE;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_DONE: begin
          if (fin_ok) begin
            out_data <= st;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cfg_hit) begin
        key[cfg_index[1:0]] <= cfg_data;
        keys_ready          <= 1'b0;
      end else if (state == ST_EXPAND && cnt == CNT_LAST) begin
        keys_ready <= 1'b1;
      end
    end
  end

  a_stale_expands: assert property (@(posedge clk) disable iff (rst)
    in_acc && !keys_ready |=> state == ST_EXPAND)
    else $error("stale round keys not expanded");

  a_round_keys: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUND |-> keys_ready)
    else $error("round without expanded keys");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_ROUND || $past(state) == ST_DONE)
    else $error("output beat without finished block");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_LAST)
    else $error("step counter out of range");

endmodule
`default_nettype wire

### rtl/aes256_round.sv
`default_nettype none
// ---------------------------------------------------------------------------
// aes256_round
// Shared round unit: initial key addition, full round, or final round
// without column mixing, selected per cycle.
// ---------------------------------------------------------------------------
module aes256_round (
  input  logic [127:0] state,
  input  logic [127:0] rkey,
  input  logic         first,
  input  logic         last,
  output logic [127:0] result
);
  import aes256_pkg::*;

  logic [7:0]   s [16];
  logic [7:0]   t [16];
  logic [7:0]   m [16];
  logic [127:0] t_flat;
  logic [127:0] m_flat;

  always_comb begin
    logic [7:0] a, b, e, d, all;
    for (int k = 0; k < 16; k++) begin
      s[k] = state[127 - 8*k -: 8];
    end
    // sub bytes with row shift
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[c*4 + i] = sbox(s[((c + i) % 4)*4 + i]);
      end
    end
    // column mixing
    for (int c = 0; c < 4; c++) begin
      a   = t[c*4];
      b   = t[c*4 + 1];
      e   = t[c*4 + 2];
      d   = t[c*4 + 3];
      all = a ^ b ^ e ^ d;
      m[c*4]     = a ^ all ^ xtime(a ^ b);
      m[c*4 + 1] = b ^ all ^ xtime(b ^ e);
      m[c*4 + 2] = e ^ all ^ xtime(e ^ d);
      m[c*4 + 3] = d ^ all ^ xtime(d ^ a);
    end
    for (int k = 0; k < 16; k++) begin
      t_flat[127 - 8*k -: 8] = t[k];
      m_flat[127 - 8*k -: 8] = m[k];
    end
  end

  always_comb begin
    if (first) begin
      result = state ^ rkey;
    end else if (last) begin
      result = t_flat ^ rkey;
    end else begin
      result = m_flat ^ rkey;
    end
  end

endmodule
`default_nettype wire

### tb/tb_aes256_block_encrypt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_aes256_block_encrypt
// Self-checking bench for the AES-256 encrypt block. Plaintext beats are
// encrypted by a local model of the cipher and key schedule, and every
// ciphertext beat is compared field by field with the oldest prediction.
// Key words change only between phases, while the block is idle. A short
// directed part covers the zero key after reset, the standard test key,
// all-ones keys, single key word changes between blocks and writes to
// unused register indexes. Random phases follow, with random idling on
// both channels except in the last phases.
// ---------------------------------------------------------------------------
module tb_aes256_block_encrypt;
  import aes256_pkg::*;

  localparam logic [CFG_IDX_W-1:0] KEY_WORD_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] KEY_WORD_1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] KEY_WORD_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] KEY_WORD_3 = CFG_IDX_W'(3);
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 153;
  localparam int CALM_PHASES = 3;
  localparam int DRAIN_WAIT  = 40;
  localparam int STALL_LIMIT = 5000;

  localparam logic [2047:0] SUB_TABLE = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  plain_t               in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  cipher_t              out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  aes256_block_encrypt DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // local copy of the key and its schedule
  logic [63:0]  key_word [KEY_WORDS];
  logic [127:0] round_key [LAST_ROUND + 1];
  bit           schedule_valid = 1'b0;

  plain_t  plain_queue[$];
  cipher_t expected_cipher[$];
  bit      idling = 1'b1;
  int      in_gap = 0;
  int      out_gap = 0;
  int      quiet_cycles = 0;
  int      errors = 0;
  int      blocks_in = 0;
  int      blocks_out = 0;
  int      key_writes = 0;
  int      unused_writes = 0;
  int      key_phases = 0;

  function automatic logic [7:0] sub_byte(input logic [7:0] v);
    return SUB_TABLE[2047 - 8 * int'(v) -: 8];
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word4(input logic [31:0] w);
    return {sub_byte(w[31:24]), sub_byte(w[23:16]), sub_byte(w[15:8]), sub_byte(w[7:0])};
  endfunction

  function automatic void expand_schedule();
    logic [31:0] w [60];
    logic [31:0] t;
    for (int k = 0; k < KEY_WORDS; k++) begin
      w[2 * k]     = key_word[k][63:32];
      w[2 * k + 1] = key_word[k][31:0];
    end
    for (int i = 8; i < 60; i++) begin
      t = w[i - 1];
      if (i % 8 == 0) begin
        t = sub_word4({t[23:0], t[31:24]}) ^ {8'h01 << (i / 8 - 1), 24'h000000};
      end else if (i % 8 == 4) begin
        t = sub_word4(t);
      end
      w[i] = w[i - 8] ^ t;
    end
    for (int r = 0; r <= LAST_ROUND; r++)
      round_key[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
    schedule_valid = 1'b1;
  endfunction

  function automatic cipher_t encrypt_block(input plain_t p);
    logic [127:0] s;
    logic [7:0]   b [16];
    logic [7:0]   a0, a1, a2, a3, mix;
    cipher_t      res;
    if (!schedule_valid) expand_schedule();
    s = {p.plain_high, p.plain_low} ^ round_key[0];
    for (int r = 1; r <= LAST_ROUND; r++) begin
      // sub bytes and shift rows
      for (int col = 0; col < 4; col++)
        for (int row = 0; row < 4; row++)
          b[col * 4 + row] = sub_byte(s[127 - 8 * (((col + row) % 4) * 4 + row) -: 8]);
      if (r < LAST_ROUND) begin
        for (int col = 0; col < 4; col++) begin
          a0  = b[col * 4];
          a1  = b[col * 4 + 1];
          a2  = b[col * 4 + 2];
          a3  = b[col * 4 + 3];
          mix = a0 ^ a1 ^ a2 ^ a3;
          s[127 - 8 * (col * 4)     -: 8] = a0 ^ mix ^ gf_double(a0 ^ a1);
          s[127 - 8 * (col * 4 + 1) -: 8] = a1 ^ mix ^ gf_double(a1 ^ a2);
          s[127 - 8 * (col * 4 + 2) -: 8] = a2 ^ mix ^ gf_double(a2 ^ a3);
          s[127 - 8 * (col * 4 + 3) -: 8] = a3 ^ mix ^ gf_double(a3 ^ a0);
        end
      end else begin
        for (int i = 0; i < 16; i++) s[127 - 8 * i -: 8] = b[i];
      end
      s = s ^ round_key[r];
    end
    res.cipher_high = s[127:64];
    res.cipher_low  = s[63:0];
    return res;
  endfunction

  function automatic logic [63:0] pick_word();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = 64'd1 << $urandom_range(0, 63);
      3: v = ~(64'd1 << $urandom_range(0, 63));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx < KEY_WORDS) begin
      key_word[idx[1:0]] = val;
      schedule_valid     = 1'b0;
      key_writes++;
    end else begin
      unused_writes++;
    end
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    key_phases++;
  endtask

  task automatic send(input logic [63:0] high, input logic [63:0] low);
    plain_t p;
    p.plain_high = high;
    p.plain_low  = low;
    plain_queue.push_back(p);
  endtask

  task automatic drain();
    @(negedge clk);
    while (plain_queue.size() != 0 || in_valid || expected_cipher.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // plaintext driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_cipher.push_back(encrypt_block(in_data));
        blocks_in++;
      end
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        in_gap   <= $urandom_range(0, 17);
      end else if (plain_queue.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= plain_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ciphertext monitor and output stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        blocks_out++;
        if (expected_cipher.size() == 0) begin
          errors++;
          $display("%0t: ciphertext beat with none expected, got %h", $time, out_data);
        end else begin
          if (out_data.cipher_high !== expected_cipher[0].cipher_high) begin
            errors++;
            $display("%0t: cipher_high mismatch, expected %h, got %h", $time,
                     expected_cipher[0].cipher_high, out_data.cipher_high);
          end
          if (out_data.cipher_low !== expected_cipher[0].cipher_low) begin
            errors++;
            $display("%0t: cipher_low mismatch, expected %h, got %h", $time,
                     expected_cipher[0].cipher_low, out_data.cipher_low);
          end
          void'(expected_cipher.pop_front());
        end
      end
      if (out_gap != 0) begin
        out_stall <= 1'b1;
        out_gap   <= out_gap - 1;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        out_gap   <= $urandom_range(0, 17);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k < KEY_WORDS; k++) key_word[k] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // zero key straight after reset, no write yet
    send('0, '0);
    send('1, '1);
    send(64'h0011223344556677, 64'h8899aabbccddeeff);
    drain();

    // standard test key
    write_reg(KEY_WORD_0, 64'h0001020304050607);
    write_reg(KEY_WORD_1, 64'h08090a0b0c0d0e0f);
    write_reg(KEY_WORD_2, 64'h1011121314151617);
    write_reg(KEY_WORD_3, 64'h18191a1b1c1d1e1f);
    end_writes();
    send(64'h0011223344556677, 64'h8899aabbccddeeff);
    send('0, '0);
    send('1, '1);
    send(64'h8000000000000000, '0);
    send('0, 64'h0000000000000001);
    drain();

    // unused indexes leave the key alone
    write_reg(CFG_IDX_W'(KEY_WORDS), '1);
    write_reg('1, {$urandom, $urandom});
    end_writes();
    send(64'h0011223344556677, 64'h8899aabbccddeeff);
    drain();

    // one key word at a time between blocks
    for (int k = 0; k < KEY_WORDS; k++) begin
      write_reg(CFG_IDX_W'(k), '1);
      end_writes();
      send({$urandom, $urandom}, {$urandom, $urandom});
      drain();
    end
    send('0, '0);
    send('1, '1);
    drain();

    for (int k = 0; k < KEY_WORDS; k++) write_reg(CFG_IDX_W'(k), '0);
    end_writes();
    send('0, '0);
    drain();

    // random phases, quiet handshakes at the end
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph >= NUM_PHASES - CALM_PHASES) idling = 1'b0;
      if (ph != 0) begin
        for (int k = 0; k < KEY_WORDS; k++)
          if ($urandom_range(0, 1) == 0) write_reg(CFG_IDX_W'(k), pick_word());
        if ($urandom_range(0, 3) == 0)
          write_reg(CFG_IDX_W'($urandom_range(KEY_WORDS, (1 << CFG_IDX_W) - 1)),
                    {$urandom, $urandom});
        end_writes();
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send(pick_word(), pick_word());
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d blocks in, %0d out, over %0d key phases", blocks_in, blocks_out,
             key_phases);
    $display("key word writes %0d, writes to unused indexes %0d", key_writes, unused_writes);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/aes256_pkg.sv
rtl/aes256_round.sv
rtl/aes256_block_encrypt.sv
tb/tb_aes256_block_encrypt.sv
